// File: rtl/core/rms_pkg.sv
// Shared types, constants and key compare functions for the multi-key record sorter.
package rms_pkg;

  localparam int DEF_MAX_RECORDS = 32;
  localparam int DEF_NAME_CHARS  = 8;

  typedef struct packed {
    logic [63:0] surname_key;
    logic [63:0] given_key;
    logic [1:0]  sector_code;
    logic [4:0]  record_tag;
    logic        final_record;
  } src_item_t;

  typedef struct packed {
    logic [4:0]  out_tag;
    logic [63:0] out_surname;
    logic [63:0] out_given;
    logic [1:0]  out_sector;
    logic        run_end;
    logic        overflowed;
  } snk_item_t;

  typedef struct packed {
    logic [63:0] surname;
    logic [63:0] given;
    logic [1:0]  sector;
    logic [4:0]  tag;
  } rec_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } st_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
    logic     desc;
  } cell_ctl_t;

  // keep the compared characters up to the first zero byte
  function automatic logic [63:0] name_key(input logic [63:0] v, input int chars);
    logic [63:0] k;
    logic        stop;
    k    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= chars || v[63 - 8*i -: 8] == 8'h00) stop = 1'b1;
      if (!stop) k[63 - 8*i -: 8] = v[63 - 8*i -: 8];
    end
    return k;
  endfunction

  // true when a must come strictly before b
  function automatic logic goes_before(input rec_t a, input rec_t b, input logic desc,
                                       input int chars);
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] ga;
    logic [63:0] gb;
    logic        lt;
    logic        gt;
    sa = name_key(a.surname, chars);
    sb = name_key(b.surname, chars);
    ga = name_key(a.given, chars);
    gb = name_key(b.given, chars);
    if (sa != sb) begin
      lt = sa < sb;
      gt = !lt;
    end else if (a.sector != b.sector) begin
      lt = a.sector < b.sector;
      gt = !lt;
    end else begin
      lt = ga < gb;
      gt = ga > gb;
    end
    return desc ? gt : lt;
  endfunction

endpackage

// File: rtl/core/rms_cell.sv
// One sorting cell: holds a record, loads, does odd-even exchange, shifts toward the output.
module rms_cell #(
  parameter int  NAME_CHARS = rms_pkg::DEF_NAME_CHARS,
  parameter bit  ODD        = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  rms_pkg::cell_ctl_t ctl,
  input  logic               load_en,
  input  rms_pkg::rec_t      load_rec,
  input  rms_pkg::rec_t      left_rec,
  input  logic               left_swap,
  input  rms_pkg::rec_t      right_rec,
  input  logic               right_valid,
  output rms_pkg::rec_t      rec,
  output logic               valid,
  output logic               swap
);

  // left member of a pair this phase and the right neighbor sorts first
  assign swap = (ctl.op == rms_pkg::CELL_SORT) && (ctl.phase == ODD) && valid && right_valid
                && rms_pkg::goes_before(right_rec, rec, ctl.desc, NAME_CHARS);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      rms_pkg::CELL_LOAD: begin
        if (load_en) rec <= load_rec;
      end
      rms_pkg::CELL_SORT: begin
        if (swap) rec <= right_rec;
        else if (left_swap) rec <= left_rec;
      end
      rms_pkg::CELL_SHIFT: rec <= right_rec;
      rms_pkg::CELL_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctl.op)
        rms_pkg::CELL_LOAD: begin
          if (load_en) valid <= 1'b1;
        end
        rms_pkg::CELL_SHIFT: valid <= right_valid;
        rms_pkg::CELL_SORT, rms_pkg::CELL_HOLD: ;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/record_multikey_sort.sv
// Top level of the multi-key record sorter: control and the chain of sorting cells.
//
//  channel | signals                         | transfer when
//  src     | src_valid, src_stall, src_item  | src_valid && !src_stall
//  snk     | snk_valid, snk_stall, snk_item  | snk_valid && !snk_stall
//  cfg     | cfg_wr_en, cfg_wr_data          | cfg_wr_en
//
// Records load one per cycle into cell fill. The final record starts n
// odd-even exchange phases, one per cycle (n = records held), then the chain
// drains from cell 0, one record per output transfer. A set of n records goes
// through n loads, n phases and n drains. src is stalled while sorting and
// draining. Synchronous reset empties the chain and returns to loading.
module record_multikey_sort #(
  parameter int MAX_RECORDS = rms_pkg::DEF_MAX_RECORDS,
  parameter int NAME_CHARS  = rms_pkg::DEF_NAME_CHARS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  rms_pkg::src_item_t src_item,
  output logic               snk_valid,
  input  logic               snk_stall,
  output rms_pkg::snk_item_t snk_item,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  rms_pkg::st_t      state;
  rms_pkg::st_t      state_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  pcnt;
  logic              drop;
  logic              desc_reg;
  logic              desc_run;
  rms_pkg::cell_ctl_t ctl;
  rms_pkg::rec_t     load_rec;
  logic              src_xfer;
  logic              snk_xfer;
  logic              room;
  logic              last_phase;

  rms_pkg::rec_t     recs  [MAX_RECORDS];
  logic              valids[MAX_RECORDS];
  logic              swaps [MAX_RECORDS];

  assign src_xfer   = src_valid && !src_stall;
  assign snk_xfer   = snk_valid && !snk_stall;
  assign room       = fill < CNT_W'(MAX_RECORDS);
  assign last_phase = (pcnt + CNT_W'(1)) == fill;

  assign load_rec.surname = src_item.surname_key;
  assign load_rec.given   = src_item.given_key;
  assign load_rec.sector  = src_item.sector_code;
  assign load_rec.tag     = src_item.record_tag;

  always_comb begin
    state_next = state;
    unique case (state)
      rms_pkg::ST_LOAD:  if (src_xfer && src_item.final_record) state_next = rms_pkg::ST_SORT;
      rms_pkg::ST_SORT:  if (last_phase) state_next = rms_pkg::ST_DRAIN;
      rms_pkg::ST_DRAIN: if (snk_xfer && fill == CNT_W'(1)) state_next = rms_pkg::ST_LOAD;
      default:           state_next = rms_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    src_stall = 1'b1;
    snk_valid = 1'b0;
    ctl.op    = rms_pkg::CELL_HOLD;
    ctl.phase = pcnt[0];
    ctl.desc  = desc_run;
    unique case (state)
      rms_pkg::ST_LOAD: begin
        src_stall = 1'b0;
        if (src_valid) ctl.op = rms_pkg::CELL_LOAD;
      end
      rms_pkg::ST_SORT: ctl.op = rms_pkg::CELL_SORT;
      rms_pkg::ST_DRAIN: begin
        snk_valid = 1'b1;
        if (!snk_stall) ctl.op = rms_pkg::CELL_SHIFT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rms_pkg::ST_LOAD;
      fill     <= '0;
      pcnt     <= '0;
      drop     <= 1'b0;
      desc_reg <= 1'b0;
      desc_run <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) desc_reg <= cfg_wr_data;
      unique case (state)
        rms_pkg::ST_LOAD: begin
          if (src_xfer) begin
            if (room) fill <= fill + CNT_W'(1);
            else drop <= 1'b1;
            pcnt     <= '0;
            desc_run <= desc_reg;
          end
        end
        rms_pkg::ST_SORT: pcnt <= pcnt + CNT_W'(1);
        rms_pkg::ST_DRAIN: begin
          if (snk_xfer) begin
            fill <= fill - CNT_W'(1);
            if (fill == CNT_W'(1)) drop <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rms_pkg::rec_t rrec;
    logic          rvalid;
    logic          lswap;
    rms_pkg::rec_t lrec;

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign rrec   = '0;
      assign rvalid = 1'b0;
    end else begin : g_mid
      assign rrec   = recs[i+1];
      assign rvalid = valids[i+1];
    end

    if (i == 0) begin : g_head
      assign lrec  = '0;
      assign lswap = 1'b0;
    end else begin : g_body
      assign lrec  = recs[i-1];
      assign lswap = swaps[i-1];
    end

    rms_cell #(
      .NAME_CHARS(NAME_CHARS),
      .ODD       (1'(i % 2))
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .load_en    (fill == CNT_W'(i)),
      .load_rec   (load_rec),
      .left_rec   (lrec),
      .left_swap  (lswap),
      .right_rec  (rrec),
      .right_valid(rvalid),
      .rec        (recs[i]),
      .valid      (valids[i]),
      .swap       (swaps[i])
    );
  end

  assign snk_item.out_tag     = recs[0].tag;
  assign snk_item.out_surname = recs[0].surname;
  assign snk_item.out_given   = recs[0].given;
  assign snk_item.out_sector  = recs[0].sector;
  assign snk_item.run_end     = fill == CNT_W'(1);
  assign snk_item.overflowed  = drop;

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(MAX_RECORDS))
    else $error("fill count beyond capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == rms_pkg::ST_DRAIN |-> fill != '0 && valids[0])
    else $error("draining with no record held");

  a_run_end_clears: assert property (@(posedge clk) disable iff (rst)
    snk_xfer && snk_item.run_end |=> state == rms_pkg::ST_LOAD && fill == '0 && !drop)
    else $error("set not cleared after last transfer");

  a_final_starts_sort: assert property (@(posedge clk) disable iff (rst)
    src_xfer && src_item.final_record |=> state == rms_pkg::ST_SORT && fill != '0)
    else $error("final record did not start sort");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for record_multikey_sort: stable multi-key sort of record sets.
`timescale 1ns / 1ps

module tb_top;

  localparam int CAP          = rms_pkg::DEF_MAX_RECORDS;
  localparam int NAME_LEN     = rms_pkg::DEF_NAME_CHARS;
  localparam int SETTLE       = 4 * CAP;
  localparam int STUCK_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 10;

  logic                clk;
  logic                rst;
  logic                src_valid;
  logic                src_stall;
  rms_pkg::src_item_t  src_item;
  logic                snk_valid;
  logic                snk_stall;
  rms_pkg::snk_item_t  snk_item;
  logic                cfg_wr_en;
  logic                cfg_wr_data;

  // mirror of the block's record store and direction
  rms_pkg::rec_t       held_rec [CAP];
  int                  held_count;
  bit                  held_dropped;
  bit                  sort_desc;
  rms_pkg::snk_item_t  sorted_run_q [$];

  int         records_sent;
  int         results_seen;
  int         sets_done;
  int         overflow_sets;
  int         desc_sets;
  int         mismatch_count;
  bit         src_idle_en;
  bit         snk_idle_en;
  int         hold_req;

  record_multikey_sort uut (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .src_item    (src_item),
    .snk_valid   (snk_valid),
    .snk_stall   (snk_stall),
    .snk_item    (snk_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // compared part of a name: leading characters up to the first zero byte
  function automatic logic [63:0] name_prefix(input logic [63:0] v);
    logic [63:0] k;
    bit          hit_zero;
    k = '0;
    hit_zero = 1'b0;
    for (int i = 0; i < NAME_LEN; i++) begin
      if (v[63 - 8*i -: 8] == 8'h00) hit_zero = 1'b1;
      if (!hit_zero) k[63 - 8*i -: 8] = v[63 - 8*i -: 8];
    end
    return k;
  endfunction

  // -1, 0, 1: a ranks below, level with, above b on surname, sector, given name
  function automatic int key_order(input rms_pkg::rec_t a, input rms_pkg::rec_t b);
    logic [63:0] ka;
    logic [63:0] kb;
    ka = name_prefix(a.surname);
    kb = name_prefix(b.surname);
    if (ka != kb) return (ka < kb) ? -1 : 1;
    if (a.sector != b.sector) return (a.sector < b.sector) ? -1 : 1;
    ka = name_prefix(a.given);
    kb = name_prefix(b.given);
    if (ka != kb) return (ka < kb) ? -1 : 1;
    return 0;
  endfunction

  function automatic void predict_sorted_run(input rms_pkg::src_item_t it);
    int                 order [CAP];
    int                 j;
    int                 c;
    rms_pkg::snk_item_t r;
    if (held_count < CAP) begin
      held_rec[held_count].surname = it.surname_key;
      held_rec[held_count].given   = it.given_key;
      held_rec[held_count].sector  = it.sector_code;
      held_rec[held_count].tag     = it.record_tag;
      held_count++;
    end else
      held_dropped = 1'b1;
    if (!it.final_record) return;
    // stable insertion sort
    for (int i = 0; i < held_count; i++) begin
      j = i;
      while (j > 0) begin
        c = key_order(held_rec[i], held_rec[order[j-1]]);
        if (sort_desc ? (c <= 0) : (c >= 0)) break;
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < held_count; i++) begin
      r.out_tag     = held_rec[order[i]].tag;
      r.out_surname = held_rec[order[i]].surname;
      r.out_given   = held_rec[order[i]].given;
      r.out_sector  = held_rec[order[i]].sector;
      r.run_end     = (i == held_count - 1);
      r.overflowed  = held_dropped;
      sorted_run_q.push_back(r);
    end
    sets_done++;
    if (held_dropped) overflow_sets++;
    if (sort_desc) desc_sets++;
    held_count = 0;
    held_dropped = 1'b0;
  endfunction

  function automatic logic [63:0] pack_name(input string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[63 - 8*i -: 8] = s[i];
    return v;
  endfunction

  function automatic rms_pkg::src_item_t make_item(input logic [63:0] sur,
                                                   input logic [63:0] giv,
                                                   input logic [1:0] sec, input logic [4:0] tag,
                                                   input logic fin);
    rms_pkg::src_item_t it;
    it.surname_key  = sur;
    it.given_key    = giv;
    it.sector_code  = sec;
    it.record_tag   = tag;
    it.final_record = fin;
    return it;
  endfunction

  // mix of raw bits, extremes, and names over A..Z or over a narrow alphabet for ties
  function automatic logic [63:0] rand_name();
    logic [63:0] v;
    int          len;
    int          top;
    v = '0;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = $urandom_range(0, 1) ? '1 : '0;
      default: begin
        if ($urandom_range(0, 1)) begin
          top = 8'h42;
          len = $urandom_range(0, 3);
        end else begin
          top = 8'h5a;
          len = $urandom_range(0, 8);
        end
        for (int i = 0; i < len; i++) v[63 - 8*i -: 8] = 8'($urandom_range(8'h41, top));
        if (len < 7 && $urandom_range(0, 3) == 0)
          for (int i = len + 1; i < 8; i++) v[63 - 8*i -: 8] = 8'($urandom_range(0, 255));
      end
    endcase
    return v;
  endfunction

  function automatic rms_pkg::src_item_t rand_record(input logic fin);
    return make_item(rand_name(), rand_name(), 2'($urandom_range(0, 3)),
                     5'($urandom_range(0, 31)), fin);
  endfunction

  task automatic send_record(input rms_pkg::src_item_t it);
    int gap;
    gap = (src_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      src_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    src_valid <= 1'b1;
    src_item  <= it;
    do @(posedge clk); while (src_stall);
    records_sent++;
    predict_sorted_run(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    src_valid <= 1'b0;
    while (sorted_run_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_direction(input bit d);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sort_desc = d;
  endtask

  task automatic run_set(input int n, input bit settle);
    for (int k = 0; k < n; k++) send_record(rand_record(k == n - 1));
    if (settle) wait_idle();
  endtask

  task automatic test_single_extremes();
    set_direction(1'b0);
    send_record(make_item('1, '1, 2'd3, 5'd31, 1'b1));
    send_record(make_item('0, '0, 2'd0, 5'd0, 1'b1));
    wait_idle();
  endtask

  // equal keys, bytes after a zero, secondary and tertiary keys, both directions
  task automatic test_key_ties();
    rms_pkg::src_item_t ties [8];
    ties[0] = make_item(pack_name("SMITH"), pack_name("ANN"), 2'd1, 5'd1, 1'b0);
    ties[1] = make_item(pack_name("SMITH"), pack_name("ANN"), 2'd1, 5'd2, 1'b0);
    ties[2] = make_item(pack_name("SMITH") | 64'h5859, pack_name("ANN"), 2'd1, 5'd3, 1'b0);
    ties[3] = make_item(pack_name("SMITH"), pack_name("ZED"), 2'd0, 5'd4, 1'b0);
    ties[4] = make_item(pack_name("SMIT"), pack_name("AL"), 2'd3, 5'd5, 1'b0);
    ties[5] = make_item(pack_name("SMITHSON"), 64'h0, 2'd2, 5'd6, 1'b0);
    ties[6] = make_item(pack_name("SMITH"), pack_name("ANNA"), 2'd1, 5'd7, 1'b0);
    ties[7] = make_item(64'h0, 64'h00AB_CDEF_0000_0000, 2'd2, 5'd8, 1'b1);
    foreach (ties[k]) send_record(ties[k]);
    wait_idle();
    set_direction(1'b1);
    foreach (ties[k]) send_record(ties[k]);
    wait_idle();
  endtask

  // full set, one with its final record dropped, one four past capacity, then a clean set
  task automatic test_capacity();
    set_direction(1'b0);
    run_set(CAP, 1'b1);
    set_direction(1'b1);
    run_set(CAP + 1, 1'b1);
    run_set(CAP + 4, 1'b1);
    run_set(3, 1'b1);
  endtask

  // sink held off while a second set queues up behind the first
  task automatic test_backpressure();
    set_direction(1'b0);
    hold_req = 300;
    run_set(10, 1'b0);
    run_set(10, 1'b1);
  endtask

  task automatic test_random_sets();
    int n;
    while (records_sent < 330) begin
      set_direction(1'($urandom_range(0, 1)));
      case ($urandom_range(0, 19))
        0:       n = $urandom_range(CAP, CAP + 4);
        1, 2, 3: n = $urandom_range(13, CAP - 1);
        default: n = $urandom_range(1, 12);
      endcase
      run_set(n, 1'b1);
    end
  endtask

  task automatic test_steady_tail();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    while (records_sent < 370) begin
      set_direction(1'($urandom_range(0, 1)));
      run_set($urandom_range(1, 8), 1'b1);
    end
  endtask

  initial begin : sink_stall_gen
    int n;
    bit held_once;
    held_once = 1'b0;
    snk_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0 && !held_once) begin
        n = hold_req;
        held_once = 1'b1;
        snk_stall <= 1'b1;
        repeat (n) @(negedge clk);
        snk_stall <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        snk_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        snk_stall <= 1'b0;
      end else
        snk_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    rms_pkg::snk_item_t want;
    bit                 bad;
    if (!rst && snk_valid && !snk_stall) begin
      results_seen++;
      if (sorted_run_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t unexpected result: tag=%h sur=%h giv=%h sec=%h end=%b ovf=%b", $time,
                   snk_item.out_tag, snk_item.out_surname, snk_item.out_given,
                   snk_item.out_sector, snk_item.run_end, snk_item.overflowed);
      end else begin
        want = sorted_run_q.pop_front();
        bad = (snk_item.out_tag !== want.out_tag) || (snk_item.out_surname !== want.out_surname)
           || (snk_item.out_given !== want.out_given) || (snk_item.out_sector !== want.out_sector)
           || (snk_item.run_end !== want.run_end) || (snk_item.overflowed !== want.overflowed);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t mismatch exp: tag=%h sur=%h giv=%h sec=%h end=%b ovf=%b", $time,
                     want.out_tag, want.out_surname, want.out_given, want.out_sector,
                     want.run_end, want.overflowed);
            $display("%0t          got: tag=%h sur=%h giv=%h sec=%h end=%b ovf=%b", $time,
                     snk_item.out_tag, snk_item.out_surname, snk_item.out_given,
                     snk_item.out_sector, snk_item.run_end, snk_item.overflowed);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((src_valid && !src_stall) || (snk_valid && !snk_stall)) stuck = 0;
      else stuck++;
    end
    $display("[record_multikey_sort] ERROR");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    src_valid    = 1'b0;
    src_item     = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    src_idle_en  = 1'b1;
    snk_idle_en  = 1'b1;
    hold_req     = 0;
    held_count   = 0;
    held_dropped = 1'b0;
    sort_desc    = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_single_extremes();
    test_key_ties();
    test_capacity();
    test_backpressure();
    test_random_sets();
    test_steady_tail();
    $display("Sorted %0d records in %0d sets (%0d descending, %0d past capacity).",
             records_sent, sets_done, desc_sets, overflow_sets);
    $display("Checked %0d output records, %0d mismatches, %0d never seen.", results_seen,
             mismatch_count, sorted_run_q.size());
    if (mismatch_count == 0 && sorted_run_q.size() == 0)
      $display("[record_multikey_sort] OK");
    else
      $display("[record_multikey_sort] ERROR");
    $finish;
  end

endmodule
